### hdl/lfu_evicting_route_counter_table_top_assert.svh
// Assertion macros for the LFU route counter table
`ifndef LFU_EVICTING_ROUTE_COUNTER_TABLE_TOP_ASSERT_SVH
`define LFU_EVICTING_ROUTE_COUNTER_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define LFUECT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lfuect assertion failed");

// next-cycle implication
`define LFUECT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lfuect assertion failed");

`endif

### hdl/lfuect_pkg.sv
// ----------------------------------------------------------------------------
// lfuect_pkg
// Types and constants shared by the LFU route counter table.
// ----------------------------------------------------------------------------
`default_nettype none

package lfuect_pkg;

    localparam int ROWS      = 32;
    localparam int KEY_W     = 64;
    localparam int CNT_W     = 64;
    localparam int IDX_W     = $clog2(ROWS);
    localparam int USED_W    = $clog2(ROWS + 1);
    localparam int CAP_W     = 6;
    localparam int STATUS_W  = 10;
    localparam int CMD_W     = 2;
    localparam int ERR_STATUS = 400;

    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD = 2'd0,
        CMD_DUMP   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_TRIM   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_DUMP,
        ST_TAIL
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] req;
        logic [CNT_W-1:0] err;
    } row_t;

endpackage

`default_nettype wire

### hdl/lfuect_cell.sv
// ----------------------------------------------------------------------------
// lfuect_cell
// One table row; loads its neighbor's row on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lfuect_cell (
    input  wire               aclk,
    input  wire               shift,
    input  lfuect_pkg::row_t  din,
    output lfuect_pkg::row_t  q
);
    import lfuect_pkg::*;

    row_t row_reg;

    always_ff @(posedge aclk) begin
        if (shift) begin
            row_reg <= din;
        end
    end

    assign q = row_reg;

endmodule

`default_nettype wire

### hdl/lfuect_chain.sv
// ----------------------------------------------------------------------------
// lfuect_chain
// Ring of row cells. Cell 0 is the head; the head's write-back enters the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module lfuect_chain (
    input  wire               aclk,
    input  wire               shift,
    input  lfuect_pkg::row_t  wb,
    output lfuect_pkg::row_t  head
);
    import lfuect_pkg::*;

    row_t q [ROWS];

    genvar i;
    generate
        for (i = 0; i < ROWS; i++) begin : g_cell
            if (i == ROWS - 1) begin : g_tail
                lfuect_cell u_cell (.aclk(aclk), .shift(shift), .din(wb), .q(q[i]));
            end else begin : g_mid
                lfuect_cell u_cell (.aclk(aclk), .shift(shift), .din(q[i+1]), .q(q[i]));
            end
        end
    endgenerate

    assign head = q[0];

endmodule

`default_nettype wire

### hdl/lfu_evicting_route_counter_table_top.sv
// ----------------------------------------------------------------------------
// lfu_evicting_route_counter_table_top
// Per-route request/error counters with least-requested eviction.
//
// channel  dir  contents
// s_       in   tuser: command; tdata: route_key, status
// m_       out  tdata: row_key, row_requests, row_errors; tuser: is_other,
//                row_valid; tlast: last
// apb      in   register 0: capacity
//
// Rows sit in a ring of 32 cells that rotates one position per step.
// Every transfer is accepted while the block is idle; clear needs nothing more.
// Record: then a match/min pass, plus a write pass on a miss.
// Trim: then a scan pass and a write pass per evicted row. Dump: then 32 steps and one tail step.
// Dump steps wait while the output register holds an untaken transfer.
// Reset empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_evicting_route_counter_table_top (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [79:0]                       s_tdata,  // route_key, status, pad
    input  wire  [lfuect_pkg::CMD_W-1:0]      s_tuser,  // command
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [191:0]                      m_tdata,  // row_key, requests, errors
    output logic [1:0]                        m_tuser,  // is_other, row_valid
    output logic                              m_tlast,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [2:0]                        paddr,
    input  wire  [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import lfuect_pkg::*;

    `include "lfu_evicting_route_counter_table_top_assert.svh"

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  t_reg, t_next;
    cmd_t              cmd_reg, cmd_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              iserr_reg, iserr_next;
    logic              matched_reg, matched_next;
    logic [IDX_W-1:0]  cold_idx_reg, cold_idx_next;
    logic [CNT_W-1:0]  cold_req_reg, cold_req_next;
    logic [CNT_W-1:0]  cold_err_reg, cold_err_next;
    row_t              lastrow_reg, lastrow_next;
    logic              copy_reg, copy_next;
    logic              ins_reg, ins_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [USED_W-1:0] rows_reg, rows_next;
    logic [CNT_W-1:0]  spreq_reg, spreq_next;
    logic [CNT_W-1:0]  sperr_reg, sperr_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic              mv_reg, mv_next;
    row_t              mrow_reg, mrow_next;
    logic              mother_reg, mother_next;
    logic              mrvalid_reg, mrvalid_next;
    logic              mlast_reg, mlast_next;

    row_t              head, wb;
    logic              step, t_end, t_in, out_free, in_xfer, match_now, cold_take;
    logic              evict, hit;
    logic [USED_W-1:0] r1;
    logic [IDX_W-1:0]  last_idx;
    logic [CAP_W-1:0]  wr_cap;

    lfuect_chain u_chain (.aclk(aclk), .shift(step), .wb(wb), .head(head));

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign t_end    = (t_reg == IDX_W'(ROWS - 1));
    assign t_in     = ({1'b0, t_reg} < rows_reg);
    assign last_idx = IDX_W'(rows_reg - USED_W'(1));
    assign step     = (state_reg == ST_SCAN) || (state_reg == ST_APPLY) ||
                      ((state_reg == ST_DUMP) && out_free);
    assign match_now = (state_reg == ST_SCAN) && (cmd_reg == CMD_RECORD) && t_in &&
                       (head.key == key_reg);
    assign cold_take = t_in && ((t_reg == '0) || (head.req < cold_req_reg));
    assign hit       = matched_reg || match_now;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (cmd_t'(s_tuser))
                        CMD_RECORD: state_next = ST_SCAN;
                        CMD_DUMP:   state_next = ST_DUMP;
                        CMD_TRIM:   state_next = (rows_reg > USED_W'(cap_reg)) ?
                                                 ST_SCAN : ST_IDLE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:  if (t_end) state_next = hit ? ST_IDLE : ST_APPLY;
            ST_APPLY: begin
                if (t_end) begin
                    state_next = ((cmd_reg == CMD_TRIM) && (rows_reg > USED_W'(cap_reg))) ?
                                 ST_SCAN : ST_IDLE;
                end
            end
            ST_DUMP:  if (step && t_end) state_next = ST_TAIL;
            ST_TAIL:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        t_next        = t_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        iserr_next    = iserr_reg;
        matched_next  = matched_reg;
        cold_idx_next = cold_idx_reg;
        cold_req_next = cold_req_reg;
        cold_err_next = cold_err_reg;
        lastrow_next  = lastrow_reg;
        copy_next     = copy_reg;
        ins_next      = ins_reg;
        slot_next     = slot_reg;
        rows_next     = rows_reg;
        spreq_next    = spreq_reg;
        sperr_next    = sperr_reg;
        cap_next      = cap_reg;
        mv_next       = mv_reg && !m_tready;
        mrow_next     = mrow_reg;
        mother_next   = mother_reg;
        mrvalid_next  = mrvalid_reg;
        mlast_next    = mlast_reg;
        wb            = head;
        evict         = 1'b0;
        r1            = rows_reg;
        wr_cap        = pwdata[CAP_W-1:0];

        if (step) begin
            t_next = t_end ? '0 : t_reg + IDX_W'(1);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    cmd_next     = cmd_t'(s_tuser);
                    key_next     = s_tdata[KEY_W-1:0];
                    iserr_next   = (s_tdata[KEY_W +: STATUS_W] >= STATUS_W'(ERR_STATUS));
                    matched_next = 1'b0;
                    t_next       = '0;
                    if (cmd_t'(s_tuser) == CMD_CLEAR) begin
                        rows_next  = '0;
                        spreq_next = '0;
                        sperr_next = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (match_now) begin
                    wb.req       = head.req + CNT_W'(1);
                    wb.err       = head.err + CNT_W'(iserr_reg);
                    matched_next = 1'b1;
                end
                if (cold_take) begin
                    cold_idx_next = t_reg;
                    cold_req_next = head.req;
                    cold_err_next = head.err;
                end
                if (t_in && (t_reg == last_idx)) begin
                    lastrow_next = head;
                end
                if (t_end && !hit) begin
                    evict = (cmd_reg == CMD_TRIM) ||
                            ((rows_reg >= USED_W'(cap_reg)) && (rows_reg != '0));
                    r1    = evict ? rows_reg - USED_W'(1) : rows_reg;
                    ins_next  = (cmd_reg == CMD_RECORD) && (r1 < USED_W'(cap_reg)) &&
                                (r1 < USED_W'(ROWS));
                    copy_next = evict && (cold_idx_next != last_idx);
                    slot_next = IDX_W'(r1);
                    rows_next = r1 + USED_W'(ins_next);
                    if (evict) begin
                        spreq_next = spreq_reg + cold_req_next;
                        sperr_next = sperr_reg + cold_err_next;
                    end
                end
            end
            ST_APPLY: begin
                if (ins_reg && (t_reg == slot_reg)) begin
                    wb.key = key_reg;
                    wb.req = CNT_W'(1);
                    wb.err = CNT_W'(iserr_reg);
                end else if (copy_reg && (t_reg == cold_idx_reg)) begin
                    wb = lastrow_reg;
                end
                if (t_end && !ins_reg && (cmd_reg == CMD_RECORD)) begin
                    spreq_next = spreq_reg + CNT_W'(1);
                    sperr_next = sperr_reg + CNT_W'(iserr_reg);
                end
            end
            ST_DUMP: begin
                if (step && t_in) begin
                    mv_next      = 1'b1;
                    mrow_next    = head;
                    mother_next  = 1'b0;
                    mrvalid_next = 1'b1;
                    mlast_next   = (t_reg == last_idx) && (spreq_reg == '0);
                end
            end
            ST_TAIL: begin
                if (out_free) begin
                    if (spreq_reg != '0) begin
                        mv_next      = 1'b1;
                        mrow_next    = '{key: '0, req: spreq_reg, err: sperr_reg};
                        mother_next  = 1'b1;
                        mrvalid_next = 1'b1;
                        mlast_next   = 1'b1;
                    end else if (rows_reg == '0) begin
                        mv_next      = 1'b1;
                        mrow_next    = '0;
                        mother_next  = 1'b0;
                        mrvalid_next = 1'b0;
                        mlast_next   = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            cap_next = ((wr_cap == '0) || (wr_cap > CAP_W'(ROWS))) ? CAP_W'(ROWS) : wr_cap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            t_reg       <= '0;
            matched_reg <= 1'b0;
            copy_reg    <= 1'b0;
            ins_reg     <= 1'b0;
            rows_reg    <= '0;
            spreq_reg   <= '0;
            sperr_reg   <= '0;
            cap_reg     <= CAP_W'(ROWS);
            mv_reg      <= 1'b0;
            cmd_reg     <= CMD_RECORD;
        end else begin
            state_reg   <= state_next;
            t_reg       <= t_next;
            matched_reg <= matched_next;
            copy_reg    <= copy_next;
            ins_reg     <= ins_next;
            rows_reg    <= rows_next;
            spreq_reg   <= spreq_next;
            sperr_reg   <= sperr_next;
            cap_reg     <= cap_next;
            mv_reg      <= mv_next;
            cmd_reg     <= cmd_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        iserr_reg    <= iserr_next;
        cold_idx_reg <= cold_idx_next;
        cold_req_reg <= cold_req_next;
        cold_err_reg <= cold_err_next;
        lastrow_reg  <= lastrow_next;
        slot_reg     <= slot_next;
        mrow_reg     <= mrow_next;
        mother_reg   <= mother_next;
        mrvalid_reg  <= mrvalid_next;
        mlast_reg    <= mlast_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {mrow_reg.err, mrow_reg.req, mrow_reg.key};
    assign m_tuser  = {mrvalid_reg, mother_reg};
    assign m_tlast  = mlast_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {{(32-CAP_W){1'b0}}, cap_reg} : 32'd0;

    `LFUECT_ASSERT_IMPL(a_rows_bound, aclk, aresetn, 1'b1, rows_reg <= USED_W'(ROWS))
    `LFUECT_ASSERT_IMPL(a_out_from_dump, aclk, aresetn, $rose(m_tvalid),
        ($past(state_reg) == ST_DUMP) || ($past(state_reg) == ST_TAIL))
    `LFUECT_ASSERT_NEXT(a_ring_steps, aclk, aresetn,
        ((state_reg == ST_SCAN) || (state_reg == ST_APPLY)) && !t_end,
        t_reg == $past(t_reg) + IDX_W'(1))

endmodule

`default_nettype wire
